// ----- src/aes128_pkg.sv -----
package aes128_pkg;

  localparam int unsigned NumRounds = 10;

  typedef logic [127:0] blk_t;
  typedef logic [NumRounds:0][127:0] rk_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [0:255][7:0] INV_SBOX = {
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // State byte k (row k%4, column k/4) sits at bits 127-8k down.
  function automatic blk_t enc_round(input blk_t s, input blk_t rk, input logic last);
    blk_t t;
    blk_t m;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)&3)+r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[127-32*c -: 8];
      a1 = t[119-32*c -: 8];
      a2 = t[111-32*c -: 8];
      a3 = t[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[127-32*c -: 8] = a0 ^ al ^ xt(a0 ^ a1);
      m[119-32*c -: 8] = a1 ^ al ^ xt(a1 ^ a2);
      m[111-32*c -: 8] = a2 ^ al ^ xt(a2 ^ a3);
      m[103-32*c -: 8] = a3 ^ al ^ xt(a3 ^ a0);
    end
    return (last ? t : m) ^ rk;
  endfunction

  function automatic blk_t dec_round(input blk_t s, input blk_t rk, input logic last);
    blk_t t;
    blk_t m;
    logic [3:0][7:0] a, x2, x4, x8, g9, g11, g13, g14;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*((c+r)&3)+r) -: 8] = INV_SBOX[s[127-8*(4*c+r) -: 8]];
      end
    end
    t = t ^ rk;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = t[127-8*(4*c+r) -: 8];
        x2[r] = xt(a[r]);
        x4[r] = xt(x2[r]);
        x8[r] = xt(x4[r]);
        g9[r] = x8[r] ^ a[r];
        g11[r] = x8[r] ^ x2[r] ^ a[r];
        g13[r] = x8[r] ^ x4[r] ^ a[r];
        g14[r] = x8[r] ^ x4[r] ^ x2[r];
      end
      m[127-32*c -: 8] = g14[0] ^ g11[1] ^ g13[2] ^ g9[3];
      m[119-32*c -: 8] = g9[0] ^ g14[1] ^ g11[2] ^ g13[3];
      m[111-32*c -: 8] = g13[0] ^ g9[1] ^ g14[2] ^ g11[3];
      m[103-32*c -: 8] = g11[0] ^ g13[1] ^ g9[2] ^ g14[3];
    end
    return last ? t : m;
  endfunction

endpackage

// ----- src/aes128_key_sched.sv -----
module aes128_key_sched (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  aes128_pkg::blk_t    key_i,
  output logic                busy_o,
  output aes128_pkg::rk_t     rk_o
);
  import aes128_pkg::*;

  logic        busy_q, busy_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  rcon_q, rcon_d;
  blk_t        cur_q, cur_d;
  rk_t         rk_q;
  logic [31:0] t, n0, n1, n2, n3;

  // One round key per cycle: step zero loads the key itself.
  always_comb begin
    t  = {SBOX[cur_q[23:16]] ^ rcon_q, SBOX[cur_q[15:8]], SBOX[cur_q[7:0]],
          SBOX[cur_q[31:24]]};
    n0 = cur_q[127:96] ^ t;
    n1 = cur_q[95:64] ^ n0;
    n2 = cur_q[63:32] ^ n1;
    n3 = cur_q[31:0] ^ n2;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rcon_d = rcon_q;
    cur_d  = cur_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == 4'(NumRounds)) begin
        busy_d = 1'b0;
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd0) begin
        cur_d  = key_i;
        rcon_d = 8'h01;
      end else begin
        cur_d  = {n0, n1, n2, n3};
        rcon_d = xt(rcon_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rcon_q <= rcon_d;
    cur_q  <= cur_d;
    if (busy_q && !start_i && cnt_q <= 4'(NumRounds)) begin
      rk_q[cnt_q] <= (cnt_q == 4'd0) ? key_i : {n0, n1, n2, n3};
    end
  end

  assign busy_o = busy_q;
  assign rk_o   = rk_q;

  a_done_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(cnt_q) == 4'(NumRounds))
    else $error("key schedule finished early");
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == 4'd0)
    else $error("key schedule did not restart");

endmodule

// ----- src/aes128_block_cipher.sv -----
// AES-128 electronic code book cipher, encrypt or decrypt per block.
// Configuration: the APB port holds the key, key_high at address 0 and
// key_low at address 8 (paddr[3] selects, the lower bits are ignored).
// After a key write, and after reset (all-zero key), the round keys are
// expanded one per cycle. s_axis_tready stays low after the write edge,
// while the registered start pulse is high and then while the eleven round
// keys are expanded, and after reset while the round keys are expanded.
// Input stream: tdata carries the block, tuser the direction (0 encrypt,
// 1 decrypt). Output stream: tdata carries the result.
// The datapath is an eleven stage pipeline, the key addition and then one
// AES round per stage, so a new block can enter in every cycle that
// s_axis_tready is high. A block passes st_q[0] up to st_q[NumRounds],
// and its result is presented from the last. All stages advance together;
// while the receiver holds m_axis_tready low with a result waiting, the
// pipeline holds and no new request is taken. Reset empties the pipeline.
module aes128_block_cipher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [63:0] block_high, [127:64] block_low
  input  logic [127:0]  s_axis_tdata,
  // [0] mode
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [63:0] result_high, [127:64] result_low
  output logic [127:0]  m_axis_tdata
);
  import aes128_pkg::*;

  logic [63:0] key_hi_q, key_lo_q;
  logic        start_q;
  logic        wr;
  logic        ks_busy;
  rk_t         rk;
  logic        en;
  logic        in_acc;

  logic [NumRounds:0]       vld_q;
  logic [NumRounds:0]       mode_q;
  blk_t [NumRounds:0]       st_q;
  blk_t [NumRounds:0]       st_d;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[3] ? key_lo_q : key_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      start_q  <= 1'b0;
    end else begin
      start_q <= wr;
      if (wr && !paddr[3]) begin
        key_hi_q <= pwdata;
      end
      if (wr && paddr[3]) begin
        key_lo_q <= pwdata;
      end
    end
  end

  aes128_key_sched u_ks (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .key_i   ({key_hi_q, key_lo_q}),
    .busy_o  (ks_busy),
    .rk_o    (rk)
  );

  assign en            = m_axis_tready || !vld_q[NumRounds];
  assign s_axis_tready = en && !ks_busy && !start_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Decryption walks the round keys backwards through the same stages.
  always_comb begin
    st_d[0] = {s_axis_tdata[63:0], s_axis_tdata[127:64]}
              ^ (s_axis_tuser ? rk[NumRounds] : rk[0]);
    for (int i = 1; i <= NumRounds; i++) begin
      st_d[i] = mode_q[i-1]
                ? dec_round(st_q[i-1], rk[NumRounds-i], i == NumRounds)
                : enc_round(st_q[i-1], rk[i], i == NumRounds);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumRounds-1:0], in_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q   <= st_d;
      mode_q <= {mode_q[NumRounds-1:0], s_axis_tuser};
    end
  end

  assign m_axis_tvalid = vld_q[NumRounds];
  assign m_axis_tdata  = {st_q[NumRounds][63:0], st_q[NumRounds][127:64]};

  a_no_acc_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !ks_busy)
    else $error("request taken during key expansion");
  a_acc_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> vld_q[0])
    else $error("accepted request lost at pipeline entry");
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

endmodule

// ----- tb/sv/tb_aes128_block_cipher.sv -----
module tb_aes128_block_cipher;
  import aes128_pkg::*;

  localparam logic [3:0] AddrKeyHigh = 4'h0;
  localparam logic [3:0] AddrKeyLow  = 4'h8;
  localparam logic ModeEnc = 1'b0;
  localparam logic ModeDec = 1'b1;
  localparam int HoldLen = 60;

  typedef struct packed {
    logic        mode;
    logic [63:0] blk_lo;
    logic [63:0] blk_hi;
  } aes_req_t;

  logic         clk_i;
  logic         rst_ni;
  logic         psel, penable, pwrite, pready;
  logic [3:0]   paddr;
  logic [63:0]  pwdata, prdata;
  logic         s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [127:0] m_axis_tdata;

  aes128_block_cipher u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  aes_req_t     pending_q[$];
  logic [127:0] cipher_q[$];
  logic [127:0] sched[0:10];
  logic [7:0]   sbox_m[0:255];
  logic [7:0]   isbox_m[0:255];
  int           err_cnt = 0;
  int           send_idle = 0;
  int           recv_stall = 0;
  int           hold_reqs = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           n_acc = 0;
  int           offer_idx = -1;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [7:0] gf2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gfmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf2(a);
    end
    return p;
  endfunction

  // S-boxes built from the field inverse and the affine map.
  task automatic build_boxes();
    logic [7:0] inv, base, b;
    int e;
    for (int x = 0; x < 256; x++) begin
      inv = (x == 0) ? 8'h00 : 8'h01;
      base = x[7:0];
      e = 254;
      if (x != 0) begin
        while (e != 0) begin
          if (e & 1) inv = gfmul(inv, base);
          base = gfmul(base, base);
          e = e >> 1;
        end
      end
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_m[x] = b;
      isbox_m[b] = x[7:0];
    end
  endtask

  function automatic logic [7:0] byte_of(input logic [127:0] v, input int k);
    return v[127-8*k -: 8];
  endfunction

  task automatic expand_schedule(input logic [63:0] kh, input logic [63:0] kl);
    logic [31:0] w[0:43];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    w[0] = kh[63:32]; w[1] = kh[31:0]; w[2] = kl[63:32]; w[3] = kl[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sbox_m[t[23:16]] ^ rc, sbox_m[t[15:8]], sbox_m[t[7:0]], sbox_m[t[31:24]]};
        rc = gf2(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] blk);
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] res;
    for (int k = 0; k < 16; k++) s[k] = byte_of(blk, k) ^ byte_of(sched[dec ? 10 : 0], k);
    for (int n = 1; n <= 10; n++) begin
      if (!dec) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4*c+r] = sbox_m[s[4*((c+r)&3)+r]];
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          if (n != 10) begin
            t[4*c]   = a0 ^ al ^ gf2(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ gf2(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ gf2(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ gf2(a3 ^ a0);
          end
        end
        for (int k = 0; k < 16; k++) s[k] = t[k] ^ byte_of(sched[n], k);
      end else begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4*((c+r)&3)+r] = isbox_m[s[4*c+r]];
        for (int k = 0; k < 16; k++) s[k] = t[k] ^ byte_of(sched[10-n], k);
        if (n != 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            s[4*c]   = gfmul(a0, 8'd14) ^ gfmul(a1, 8'd11) ^ gfmul(a2, 8'd13)
                       ^ gfmul(a3, 8'd9);
            s[4*c+1] = gfmul(a0, 8'd9) ^ gfmul(a1, 8'd14) ^ gfmul(a2, 8'd11)
                       ^ gfmul(a3, 8'd13);
            s[4*c+2] = gfmul(a0, 8'd13) ^ gfmul(a1, 8'd9) ^ gfmul(a2, 8'd14)
                       ^ gfmul(a3, 8'd11);
            s[4*c+3] = gfmul(a0, 8'd11) ^ gfmul(a1, 8'd13) ^ gfmul(a2, 8'd9)
                       ^ gfmul(a3, 8'd14);
          end
        end
      end
    end
    for (int k = 0; k < 16; k++) res[127-8*k -: 8] = s[k];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  // Request acceptance is taken at the rising edge, where the handshake counts.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      cipher_q.push_back(cipher_block(s_axis_tuser,
                                      {s_axis_tdata[63:0], s_axis_tdata[127:64]}));
      void'(pending_q.pop_front());
      n_acc++;
    end
  end

  // Request driver: a request on the bus stays unchanged until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(s_axis_tvalid && offer_idx == n_acc)) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_q[0].blk_lo, pending_q[0].blk_hi};
          s_axis_tuser  <= pending_q[0].mode;
          offer_idx = n_acc;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with its own count for a long hold.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[63:0], 64'h0);
      end else begin
        if (m_axis_tdata[63:0] !== cipher_q[0][127:64])
          report_mismatch("result_high", m_axis_tdata[63:0], cipher_q[0][127:64]);
        if (m_axis_tdata[127:64] !== cipher_q[0][63:0])
          report_mismatch("result_low", m_axis_tdata[127:64], cipher_q[0][63:0]);
        void'(cipher_q.pop_front());
      end
    end
  end

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_key(input logic [63:0] kh, input logic [63:0] kl);
    apb_write(AddrKeyHigh, kh);
    apb_write(AddrKeyLow, kl);
    expand_schedule(kh, kl);
  endtask

  task automatic queue_block(input logic m, input logic [63:0] hi, input logic [63:0] lo);
    aes_req_t r;
    r.mode = m; r.blk_hi = hi; r.blk_lo = lo;
    pending_q.push_back(r);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0);
    wait (cipher_q.size() == 0);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_phase(input int n, input int s_idle, input int r_stall);
    send_idle = s_idle;
    recv_stall = r_stall;
    for (int i = 0; i < n; i++) queue_block(1'($urandom_range(1)), rand64(), rand64());
    drain();
  endtask

  initial begin
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0; m_axis_tready = 0;
    build_boxes();
    expand_schedule(64'h0, 64'h0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset key, then the standard test vector and its inverse.
    queue_block(ModeEnc, 64'h0, 64'h0);
    queue_block(ModeDec, 64'h0, 64'h0);
    queue_block(ModeEnc, '1, '1);
    queue_block(ModeDec, '1, '1);
    drain();
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    queue_block(ModeEnc, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(ModeDec, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    queue_block(ModeEnc, 64'h8000000000000000, 64'h0000000000000001);
    queue_block(ModeDec, 64'h0000000000000001, 64'h8000000000000000);
    drain();
    set_key('1, '1);
    queue_block(ModeEnc, '1, 64'h0);
    queue_block(ModeDec, 64'h0, '1);
    queue_block(ModeEnc, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();

    random_phase(100, 0, 0);
    set_key(rand64(), rand64());
    random_phase(80, 74, 0);
    apb_write(AddrKeyLow, rand64());
    expand_schedule(64'hffffffffffffffff, 64'h0);
    set_key(64'hffffffffffffffff, 64'h0);
    random_phase(80, 0, 74);
    set_key(rand64(), rand64());
    random_phase(60, 29, 29);

    // Long receiver hold while requests keep coming, so the input stalls.
    send_idle = 0;
    recv_stall = 0;
    for (int i = 0; i < 40; i++) queue_block(1'($urandom_range(1)), rand64(), rand64());
    hold_reqs++;
    drain();
    set_key(64'h0, 64'h0);
    random_phase(40, 10, 10);

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
